// ----- hw/rtl/rssa_pkg.sv -----
package rssa_pkg;

  // Field widths fixed by the item format.
  localparam int LANE_W       = 2;
  localparam int CNT_W        = 8;
  localparam int DEN_W        = 16;
  localparam int BUDGET_W     = 10;
  localparam int STATUS_W     = 3;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 40;

  // Configuration register map.
  localparam int CFG_IDX_W    = 3;
  localparam int RESERVE_REGS = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SLOTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVE0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] MAX_SLOTS_RST = 8'd8;
  localparam logic [CNT_W-1:0] RESERVE_RST [RESERVE_REGS] = '{8'd1, 8'd1, 8'd1, 8'd0};

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [DEN_W-1:0] DEN_MAX = '1;

  // Operation codes carried on the input side.
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_RSV_GRANT   = 3'd0,
    ST_SHR_GRANT   = 3'd1,
    ST_OVER_BUDGET = 3'd2,
    ST_POOL_EMPTY  = 3'd3,
    ST_RELEASED    = 3'd4,
    ST_REL_ERROR   = 3'd5
  } rssa_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted input item
    logic commit;  // decide the held item, update counters, load the result
  } rssa_cmd_t;

endpackage

// ----- hw/rtl/rssa_ctrl.sv -----
module rssa_ctrl
  import rssa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output rssa_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.load   = in_tvalid && (state_r == S_IDLE);
    // The result register must be free, or be emptied in this cycle.
    cmd.commit = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.load) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/rssa_dp.sv -----
module rssa_dp
  import rssa_pkg::*;
#(
  parameter int LANES        = 4,
  parameter int SHARED_SLOTS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rssa_cmd_t              cmd,
  input  logic                   in_op,
  input  logic [LANE_W-1:0]      in_lane,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data,
  output logic [STATUS_W-1:0]    out_status,
  output logic [OUT_TDATA_W-1:0] out_payload
);

  localparam logic [CNT_W-1:0] POOL_RST = CNT_W'(SHARED_SLOTS);

  // Configuration registers.
  logic [CNT_W-1:0] max_slots_r;
  logic [CNT_W-1:0] reserve_r [RESERVE_REGS];

  // Held input item.
  logic              op_r;
  logic [LANE_W-1:0] lane_r;

  // Counters.
  logic [CNT_W-1:0] lane_cnt_r [LANES];
  logic [DEN_W-1:0] den_r      [LANES];
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] pool_r;

  // Result register.
  logic [STATUS_W-1:0]    status_r;
  logic [OUT_TDATA_W-1:0] payload_r;

  logic                 lane_ok;
  logic [CNT_W-1:0]     lc_sel;
  logic [DEN_W-1:0]     dc_sel;
  logic [CNT_W-1:0]     res;
  logic [BUDGET_W-1:0]  budget;
  logic [CNT_W-1:0]     lc_nxt;
  logic [DEN_W-1:0]     dc_nxt;
  logic [CNT_W-1:0]     total_nxt;
  logic [CNT_W-1:0]     pool_nxt;
  rssa_status_t         status_nxt;
  logic                 deny;
  logic [BUDGET_W-1:0]  diff;
  logic [CNT_W-1:0]     avail;
  logic [CFG_IDX_W-1:0] rsv_idx;

  assign rsv_idx = cfg_index - REG_RESERVE0;

  always_comb begin
    lane_ok = (int'(lane_r) < LANES);
    lc_sel  = '0;
    dc_sel  = '0;
    for (int i = 0; i < LANES; i++) begin
      if (int'(lane_r) == i) begin
        lc_sel = lane_cnt_r[i];
        dc_sel = den_r[i];
      end
    end
    res = lane_ok ? reserve_r[lane_r] : '0;

    // Budget is the larger of max_slots and the sum of existing lanes' reserves.
    budget = '0;
    for (int i = 0; i < RESERVE_REGS; i++) begin
      if (i < LANES) begin
        budget = budget + BUDGET_W'(reserve_r[i]);
      end
    end
    if (BUDGET_W'(max_slots_r) > budget) begin
      budget = BUDGET_W'(max_slots_r);
    end

    lc_nxt     = lc_sel;
    dc_nxt     = dc_sel;
    total_nxt  = total_r;
    pool_nxt   = pool_r;
    deny       = 1'b0;
    status_nxt = ST_OVER_BUDGET;

    if (!lane_ok) begin
      status_nxt = (op_r == OP_RELEASE) ? ST_REL_ERROR : ST_OVER_BUDGET;
    end else if (op_r == OP_ACQUIRE) begin
      if (total_r == CNT_MAX) begin
        status_nxt = ST_OVER_BUDGET;
        deny       = 1'b1;
      end else if (lc_sel < res) begin
        lc_nxt     = lc_sel + 1'b1;
        total_nxt  = total_r + 1'b1;
        status_nxt = ST_RSV_GRANT;
      end else if (BUDGET_W'(total_r) >= budget) begin
        status_nxt = ST_OVER_BUDGET;
        deny       = 1'b1;
      end else if (pool_r != '0) begin
        pool_nxt   = pool_r - 1'b1;
        lc_nxt     = lc_sel + 1'b1;
        total_nxt  = total_r + 1'b1;
        status_nxt = ST_SHR_GRANT;
      end else begin
        status_nxt = ST_POOL_EMPTY;
        deny       = 1'b1;
      end
      if (deny && (dc_sel != DEN_MAX)) begin
        dc_nxt = dc_sel + 1'b1;
      end
    end else begin
      if (lc_sel == '0) begin
        status_nxt = ST_REL_ERROR;
      end else begin
        lc_nxt = lc_sel - 1'b1;
        if (total_r != '0) begin
          total_nxt = total_r - 1'b1;
        end
        // Never refill the pool above its size; this can happen after a
        // reserve was lowered while the lane held slots.
        if ((lc_sel > res) && (pool_r < POOL_RST)) begin
          pool_nxt = pool_r + 1'b1;
        end
        status_nxt = ST_RELEASED;
      end
    end

    diff = (BUDGET_W'(total_nxt) < budget) ? (budget - BUDGET_W'(total_nxt)) : '0;
    avail = (diff > BUDGET_W'(CNT_MAX)) ? CNT_MAX : diff[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_slots_r <= MAX_SLOTS_RST;
      for (int i = 0; i < RESERVE_REGS; i++) begin
        reserve_r[i] <= RESERVE_RST[i];
      end
      for (int i = 0; i < LANES; i++) begin
        lane_cnt_r[i] <= '0;
        den_r[i]      <= '0;
      end
      total_r <= '0;
      pool_r  <= POOL_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_SLOTS) begin
          max_slots_r <= cfg_data;
        end else if (cfg_index < REG_COUNT) begin
          reserve_r[rsv_idx[LANE_W-1:0]] <= cfg_data;
        end
      end
      if (cmd.commit) begin
        for (int i = 0; i < LANES; i++) begin
          if (int'(lane_r) == i) begin
            lane_cnt_r[i] <= lc_nxt;
            den_r[i]      <= dc_nxt;
          end
        end
        total_r <= total_nxt;
        pool_r  <= pool_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      lane_r <= in_lane;
    end
    if (cmd.commit) begin
      status_r  <= status_nxt;
      payload_r <= {(lane_ok ? dc_nxt : {DEN_W{1'b0}}), avail, total_nxt,
                    (lane_ok ? lc_nxt : {CNT_W{1'b0}})};
    end
  end

  assign out_status  = status_r;
  assign out_payload = payload_r;

endmodule

// ----- hw/rtl/reserved_shared_slot_admission.sv -----
// Channel   Direction  Handshake            Payload
// in_       input      in_tvalid/in_tready  tuser: operation, tdata: lane
// out_      output     out_tvalid/out_tready tuser: status, tdata: counters
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item is captured in S_IDLE and then decided in S_EXEC, which also
// updates the lane counters; no new item is accepted until it is decided.
// The result sits in an output register; the next item is captured while it
// waits, and only its decision stalls until that register is emptied.
// Reset (rst_n low, synchronous) clears all counters, fills the shared pool
// and restores the configuration registers to their defaults.
module reserved_shared_slot_admission
  import rssa_pkg::*;
#(
  parameter int LANES        = 4,
  parameter int SHARED_SLOTS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input items.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tuser,   // [0] operation (0 acquire, 1 release)
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] lane, upper bits zero
  // Result items.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [STATUS_W-1:0]    out_tuser,  // [2:0] status
  // [7:0] lane_in_use, [15:8] total_in_use, [23:16] available,
  // [39:24] lane_denials
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data
);

  rssa_cmd_t cmd;

  // Register writes are always accepted; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  // The controller sequences capture, decision and the result handshake.
  rssa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // The datapath holds configuration, per-lane counters, the pool and the
  // result register.
  rssa_dp #(
    .LANES        (LANES),
    .SHARED_SLOTS (SHARED_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_op       (in_tuser),
    .in_lane     (in_tdata[LANE_W-1:0]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_status  (out_tuser),
    .out_payload (out_tdata)
  );

endmodule

// ----- tb/slot_admission_checker.sv -----
`timescale 1ns / 1ps

module slot_admission_checker
  import rssa_pkg::*;
#(
  parameter int LANES        = 4,
  parameter int SHARED_SLOTS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic                   in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [STATUS_W-1:0]    out_tuser,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data,
  output int unsigned            results_seen,
  output int unsigned            mismatches
);

  typedef struct packed {
    rssa_status_t     status;
    logic [CNT_W-1:0] lane_use;
    logic [CNT_W-1:0] total_use;
    logic [CNT_W-1:0] avail;
    logic [DEN_W-1:0] denials;
  } verdict_t;

  logic [CNT_W-1:0] max_slots;
  logic [CNT_W-1:0] reserve [RESERVE_REGS];
  logic [CNT_W-1:0] lane_held [LANES];
  logic [CNT_W-1:0] total_held;
  logic [CNT_W-1:0] pool_free;
  logic [DEN_W-1:0] lane_denied [LANES];

  // Verdicts predicted for accepted requests, oldest first.
  verdict_t pending_verdicts[$];

  // Lanes without a reserve register of their own have no reserve.
  function automatic logic [CNT_W-1:0] reserve_of(int l);
    return (l < RESERVE_REGS && l < LANES) ? reserve[l] : '0;
  endfunction

  function automatic logic [BUDGET_W-1:0] admission_budget();
    logic [BUDGET_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < RESERVE_REGS; i++) sum += BUDGET_W'(reserve_of(i));
    return (sum > BUDGET_W'(max_slots)) ? sum : BUDGET_W'(max_slots);
  endfunction

  function automatic void count_denial(int l);
    if (lane_denied[l] != DEN_MAX) lane_denied[l]++;
  endfunction

  function automatic verdict_t decide_admission(logic op, logic [LANE_W-1:0] ln);
    verdict_t         v;
    logic [BUDGET_W-1:0] room;
    logic [CNT_W-1:0] prev;
    int               l;
    l = int'(ln);
    v = '0;
    if (l >= LANES) begin
      v.status = (op == OP_RELEASE) ? ST_REL_ERROR : ST_OVER_BUDGET;
    end else if (op == OP_ACQUIRE) begin
      // A full total counter refuses even a lane that still has reserve left.
      if (total_held == CNT_MAX) begin
        v.status = ST_OVER_BUDGET;
        count_denial(l);
      end else if (lane_held[l] < reserve_of(l)) begin
        lane_held[l]++;
        total_held++;
        v.status = ST_RSV_GRANT;
      end else if (BUDGET_W'(total_held) >= admission_budget()) begin
        v.status = ST_OVER_BUDGET;
        count_denial(l);
      end else if (pool_free != '0) begin
        pool_free--;
        lane_held[l]++;
        total_held++;
        v.status = ST_SHR_GRANT;
      end else begin
        v.status = ST_POOL_EMPTY;
        count_denial(l);
      end
    end else if (lane_held[l] == '0) begin
      v.status = ST_REL_ERROR;
    end else begin
      prev = lane_held[l];
      lane_held[l]--;
      if (total_held != '0) total_held--;
      // The pool never grows past its size, even when a reserve shrank under a busy lane.
      if (prev > reserve_of(l) && pool_free < SHARED_SLOTS) pool_free++;
      v.status = ST_RELEASED;
    end

    room = admission_budget();
    room = (BUDGET_W'(total_held) < room) ? room - BUDGET_W'(total_held) : '0;
    v.avail = (room > BUDGET_W'(CNT_MAX)) ? CNT_MAX : room[CNT_W-1:0];
    v.total_use = total_held;
    if (l < LANES) begin
      v.lane_use = lane_held[l];
      v.denials = lane_denied[l];
    end
    return v;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      max_slots = MAX_SLOTS_RST;
      for (int i = 0; i < RESERVE_REGS; i++) reserve[i] = RESERVE_RST[i];
      for (int i = 0; i < LANES; i++) begin
        lane_held[i] = '0;
        lane_denied[i] = '0;
      end
      total_held = '0;
      pool_free = CNT_W'(SHARED_SLOTS);
      pending_verdicts.delete();
      mismatches = 0;
      results_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (pending_verdicts.size() == 0) begin
          $error("result item: expected none, actual status %0d", out_tuser);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("lane_in_use", want.lane_use, out_tdata[7:0]);
          check_field("total_in_use", want.total_use, out_tdata[15:8]);
          check_field("available", want.avail, out_tdata[23:16]);
          check_field("lane_denials", want.denials, out_tdata[39:24]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_SLOTS) begin
          max_slots = cfg_data;
        end else if (cfg_index >= REG_RESERVE0 && cfg_index < REG_COUNT) begin
          reserve[cfg_index - REG_RESERVE0] = cfg_data;
        end
      end
      if (in_tvalid && in_tready) begin
        pending_verdicts.push_back(decide_admission(in_tuser, in_tdata[LANE_W-1:0]));
      end
    end
  end

endmodule

// ----- tb/tb_reserved_shared_slot_admission.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the slot admission controller. The checker beside
// the block watches all three channels, predicts every result item and counts
// the mismatches; this module only drives the block and reports the outcome.
module tb_reserved_shared_slot_admission;
  import rssa_pkg::*;

  localparam int LANES        = 4;
  localparam int SHARED_SLOTS = 4;
  localparam int PHASES       = 8;
  localparam int RANDOM_ITEMS = 1080;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic                   in_tuser;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [STATUS_W-1:0]    out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CNT_W-1:0]       cfg_data;

  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  reserved_shared_slot_admission #(
    .LANES        (LANES),
    .SHARED_SLOTS (SHARED_SLOTS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  slot_admission_checker #(
    .LANES        (LANES),
    .SHARED_SLOTS (SHARED_SLOTS)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tuser     (in_tuser),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tuser    (out_tuser),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .results_seen (results_seen),
    .mismatches   (mismatches)
  );

  // The receiver draws a fresh ready every cycle, so stalls land on every
  // phase of the block's item handling.
  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Hard stop in case the block hangs; far above the slowest correct run.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct <= 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 76;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct <= 76;
      end
      default: begin
        send_idle_pct = 27;
        stall_pct <= 27;
      end
    endcase
  endtask

  // Presents one item, possibly after a few idle cycles, and returns at the
  // edge where it is accepted. The valid stays high so that back-to-back items
  // never drop it within one time step.
  task automatic send_item(input logic op, input logic [LANE_W-1:0] ln);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= IN_TDATA_W'(ln);
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stops sending and waits until every item has produced its result item.
  // Each item yields exactly one result, so the block is idle afterwards.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_seen < items_sent);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Rewrites the whole register set while the block is idle.
  task automatic configure(input logic [CNT_W-1:0] slots,
                           input logic [CNT_W-1:0] rsv [RESERVE_REGS]);
    settle();
    write_reg(REG_MAX_SLOTS, slots);
    for (int i = 0; i < RESERVE_REGS; i++) begin
      write_reg(REG_RESERVE0 + CFG_IDX_W'(i), rsv[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random traffic in short bursts on one lane, so that lanes climb through
  // their reserve into the shared pool and back down again.
  task automatic run_mix(input int unsigned count, input int unsigned acquire_pct);
    int unsigned done;
    int unsigned burst;
    logic        op;
    logic [LANE_W-1:0] ln;
    done = 0;
    while (done < count) begin
      op = ($urandom_range(99) < acquire_pct) ? OP_ACQUIRE : OP_RELEASE;
      ln = LANE_W'($urandom_range(LANES - 1));
      burst = $urandom_range(1, 5);
      repeat (burst) begin
        send_item(op, ln);
        done++;
      end
    end
  endtask

  initial begin
    logic [CNT_W-1:0] slots;
    logic [CNT_W-1:0] rsv [RESERVE_REGS];

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= OP_ACQUIRE;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_MAX_SLOTS;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Opening sequence on the reset configuration: budget 8, reserves 1/1/1/0
    // and a pool of four. Releases on idle lanes come first, then the lanes
    // fill through their reserves into the pool until it runs dry.
    send_item(OP_RELEASE, 2'd3);
    send_item(OP_RELEASE, 2'd0);
    send_item(OP_ACQUIRE, 2'd0);
    send_item(OP_ACQUIRE, 2'd0);
    send_item(OP_ACQUIRE, 2'd1);
    send_item(OP_ACQUIRE, 2'd2);
    send_item(OP_ACQUIRE, 2'd3);
    send_item(OP_ACQUIRE, 2'd3);
    send_item(OP_ACQUIRE, 2'd3);
    send_item(OP_ACQUIRE, 2'd1);
    send_item(OP_ACQUIRE, 2'd2);

    // With max_slots at zero the budget falls to the sum of the reserves,
    // which the lanes already exceed, so further acquires are over budget.
    rsv = '{8'd1, 8'd1, 8'd1, 8'd0};
    configure('0, rsv);
    send_item(OP_ACQUIRE, 2'd1);
    send_item(OP_ACQUIRE, 2'd3);

    // Lowering lane zero's reserve while it holds slots makes its releases
    // return slots to the pool; lane three then tries to overfill the pool.
    rsv = '{8'd0, 8'd1, 8'd1, 8'd0};
    configure(8'd8, rsv);
    send_item(OP_RELEASE, 2'd0);
    send_item(OP_RELEASE, 2'd0);
    send_item(OP_RELEASE, 2'd3);
    send_item(OP_RELEASE, 2'd3);
    send_item(OP_RELEASE, 2'd3);
    send_item(OP_RELEASE, 2'd3);
    send_item(OP_RELEASE, 2'd1);
    send_item(OP_RELEASE, 2'd2);

    // Random phases, each with its own register set and idling pattern.
    // Reconfiguring between phases leaves lanes holding slots under changed
    // reserves, which exercises the pool return rules further.
    for (int ph = 0; ph < PHASES; ph++) begin
      slots = CNT_W'($urandom_range(12));
      foreach (rsv[i]) rsv[i] = CNT_W'($urandom_range(3));
      case (ph)
        1: begin
          slots = CNT_MAX;
          foreach (rsv[i]) rsv[i] = '0;
        end
        3: begin
          slots = '0;
        end
        5: begin
          rsv[$urandom_range(RESERVE_REGS - 1)] = CNT_MAX;
        end
        default: begin
        end
      endcase
      configure(slots, rsv);
      set_idling(idle_mode_t'(ph % 4));
      run_mix(RANDOM_ITEMS / PHASES, $urandom_range(35, 75));
    end

    // Full reserves push the budget past 255, so available saturates. Lane
    // zero then fills the total counter, after which even a lane with reserve
    // left is refused as over budget.
    foreach (rsv[i]) rsv[i] = CNT_MAX;
    configure('0, rsv);
    set_idling(IDLE_BOTH);
    repeat (int'(CNT_MAX) + 1) send_item(OP_ACQUIRE, 2'd0);
    repeat (3) send_item(OP_ACQUIRE, 2'd1);
    send_item(OP_ACQUIRE, 2'd3);

    // Drop every reserve, drain lane zero completely and give the other lanes
    // a few releases; the pool stays capped at its size while returned slots
    // keep arriving.
    foreach (rsv[i]) rsv[i] = '0;
    configure('0, rsv);
    repeat (int'(CNT_MAX) + 1) send_item(OP_RELEASE, 2'd0);
    for (int ln = 1; ln < LANES; ln++) begin
      repeat (8) send_item(OP_RELEASE, LANE_W'(ln));
    end

    // A zero budget denies every acquire, so the denial counter of one lane
    // keeps climbing.
    settle();
    set_idling(IDLE_NONE);
    repeat (16) send_item(OP_ACQUIRE, 2'd2);
    send_item(OP_ACQUIRE, 2'd1);
    send_item(OP_RELEASE, 2'd2);

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
